### rtl/isa_pkg.sv
`timescale 1ns / 1ps
// isa_pkg: item types, opcodes, status codes and cell commands
// shared by the shift array cells and the top level; no dependencies

package isa_pkg;

  localparam logic [3:0] OP_APPEND   = 4'd0;
  localparam logic [3:0] OP_INSERT   = 4'd1;
  localparam logic [3:0] OP_DELETE   = 4'd2;
  localparam logic [3:0] OP_CHANGE   = 4'd3;
  localparam logic [3:0] OP_READ     = 4'd4;
  localparam logic [3:0] OP_DROP     = 4'd5;
  localparam logic [3:0] OP_CLEAR    = 4'd6;
  localparam logic [3:0] OP_BACKUP   = 4'd7;
  localparam logic [3:0] OP_RESTORE  = 4'd8;
  localparam logic [3:0] OP_TRUNCATE = 4'd9;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_INDEX = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_NO_BACKUP = 3'd4;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_WRITE,
    CELL_BACKUP,
    CELL_RESTORE
  } cell_cmd_t;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [6:0]  index;
    logic [63:0] value;
  } isa_in_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic [6:0]  length;
    logic [2:0]  status;
  } isa_out_t;

endpackage

### rtl/isa_cell.sv
`timescale 1ns / 1ps
// isa_cell: one entry of the shift array with its backup word and a read bus stage
// depends on isa_pkg

module isa_cell import isa_pkg::*; #(
  parameter int PW  = 7,
  parameter int POS = 0
) (
  input  logic          clk,
  input  cell_cmd_t     cmd,
  input  logic [PW-1:0] pos,
  input  logic [63:0]   value,
  input  logic [63:0]   left_word,
  input  logic [63:0]   right_word,
  input  logic [63:0]   rd_in,
  output logic [63:0]   word,
  output logic [63:0]   rd_out
);

  logic [63:0] bword;
  logic        hit;
  logic        above;

  assign hit   = (pos == PW'(POS));
  assign above = (pos < PW'(POS));

  always_ff @(posedge clk) begin
    case (cmd)
      CELL_INSERT: begin
        if (above) begin
          word <= left_word;
        end else if (hit) begin
          word <= value;
        end
      end
      CELL_DELETE: begin
        if (above || hit) begin
          word <= right_word;
        end
      end
      CELL_WRITE: begin
        if (hit) begin
          word <= value;
        end
      end
      CELL_BACKUP:  bword <= word;
      CELL_RESTORE: word <= bword;
      default: ;
    endcase
    // read bus: the addressed cell puts its word on, the others pass it along
    rd_out <= hit ? word : rd_in;
  end

endmodule

### rtl/indexed_shift_array_with_snapshot.sv
`timescale 1ns / 1ps
// indexed_shift_array_with_snapshot: top level, opcode decode, fill counts and the cell row
// depends on isa_pkg and isa_cell
//
//   channel   signals                     direction   accepted when
//   request   start, busy, request        in          start && !busy
//   result    done, result                out         done (one cycle)
//
// every opcode but a successful read needs no walk; its result follows on the next cycle
// a successful read holds busy high while the word walks the
// registered read bus through all DEPTH cells; its result follows in the cycle after
// reset clears the state, fill count, backup count, walk counter and done; entries need no clearing pass
// results cannot be stalled: done is high for exactly one cycle

module indexed_shift_array_with_snapshot import isa_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  isa_in_t  request,
  output logic     busy,
  output logic     done,
  output isa_out_t result
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 7) ? CW : 7;

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t        state;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic [CW-1:0] bcnt;
  logic [CW-1:0] walk;
  logic [PW-1:0] rpos;
  logic [2:0]    st_next;
  logic          go_read;
  logic          accept;
  logic          full;
  logic [PW-1:0] idx_w;
  logic [PW-1:0] cnt_w;
  logic [PW-1:0] cell_pos;
  cell_cmd_t     cell_cmd;
  logic [63:0]   words [DEPTH];
  logic [63:0]   rd    [DEPTH];

  assign accept = start && (state == S_IDLE);
  assign idx_w  = PW'(request.index);
  assign cnt_w  = PW'(cnt);
  assign full   = (cnt == CW'(DEPTH));
  assign busy   = (state == S_READ);

  always_comb begin
    cnt_next = cnt;
    st_next  = ST_OK;
    go_read  = 1'b0;
    cell_cmd = CELL_HOLD;
    cell_pos = idx_w;
    if (state == S_READ) begin
      cell_pos = rpos;
    end else if (accept) begin
      unique case (request.opcode)
        OP_APPEND: begin
          cell_pos = cnt_w;
          if (full) begin
            st_next = ST_FULL;
          end else begin
            cell_cmd = CELL_INSERT;
            cnt_next = cnt + 1'b1;
          end
        end
        OP_INSERT: begin
          if (idx_w > cnt_w) begin
            st_next = ST_BAD_INDEX;
          end else if (full) begin
            st_next = ST_FULL;
          end else begin
            cell_cmd = CELL_INSERT;
            cnt_next = cnt + 1'b1;
          end
        end
        OP_DELETE: begin
          if (idx_w >= cnt_w) begin
            st_next = ST_BAD_INDEX;
          end else begin
            cell_cmd = CELL_DELETE;
            cnt_next = cnt - 1'b1;
          end
        end
        OP_CHANGE: begin
          if (idx_w >= cnt_w) begin
            st_next = ST_BAD_INDEX;
          end else begin
            cell_cmd = CELL_WRITE;
          end
        end
        OP_READ: begin
          if (idx_w >= cnt_w) begin
            st_next = ST_BAD_INDEX;
          end else begin
            go_read = 1'b1;
          end
        end
        OP_DROP: begin
          if (cnt == '0) begin
            st_next = ST_EMPTY;
          end else begin
            cnt_next = cnt - 1'b1;
          end
        end
        OP_CLEAR: cnt_next = '0;
        OP_BACKUP: cell_cmd = CELL_BACKUP;
        OP_RESTORE: begin
          if (bcnt == '0) begin
            st_next = ST_NO_BACKUP;
          end else begin
            cell_cmd = CELL_RESTORE;
            cnt_next = bcnt;
          end
        end
        OP_TRUNCATE: begin
          if (idx_w == '0 || idx_w > PW'(DEPTH)) begin
            st_next = ST_BAD_INDEX;
          end else if (idx_w < cnt_w) begin
            cnt_next = CW'(idx_w);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      bcnt  <= '0;
      walk  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cnt  <= cnt_next;
            rpos <= idx_w;
            walk <= '0;
            if (request.opcode == OP_BACKUP) begin
              bcnt <= cnt;
            end
            if (go_read) begin
              state <= S_READ;
            end else begin
              done             <= 1'b1;
              result.read_data <= '0;
              result.length    <= 7'(cnt_next);
              result.status    <= st_next;
            end
          end
        end
        S_READ: begin
          walk <= walk + 1'b1;
          if (walk == CW'(DEPTH)) begin
            state            <= S_IDLE;
            done             <= 1'b1;
            result.read_data <= rd[DEPTH-1];
            result.length    <= 7'(cnt);
            result.status    <= ST_OK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [63:0] left_word;
    logic [63:0] right_word;
    logic [63:0] rd_in;
    if (k == 0) begin : g_first
      assign left_word = '0;
      assign rd_in     = '0;
    end else begin : g_inner
      assign left_word = words[k-1];
      assign rd_in     = rd[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_body
      assign right_word = words[k+1];
    end
    isa_cell #(
      .PW  (PW),
      .POS (k)
    ) u_cell (
      .clk        (clk),
      .cmd        (cell_cmd),
      .pos        (cell_pos),
      .value      (request.value),
      .left_word  (left_word),
      .right_word (right_word),
      .rd_in      (rd_in),
      .word       (words[k]),
      .rd_out     (rd[k])
    );
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("result strobe during read walk");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH) && bcnt <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_busy_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(request.opcode) == OP_READ && $past(start))
    else $error("walk started by an item that is not a read");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ST_OK |-> result.read_data == '0)
    else $error("failed item returned data");

  a_length_hold: assert property (@(posedge clk) disable iff (rst)
    busy && !$rose(busy) |-> $stable(cnt))
    else $error("fill count changed during read");

endmodule
